>>> design/svr_pkg.sv
// Shared types, constants and the control program of the sumcheck round verifier.
`timescale 1ns / 1ps

package svr_pkg;

  localparam logic [30:0] FIELD_P = 31'h7FFF_FFFF;

  localparam int UC_DEPTH = 12;
  localparam int UC_AW    = $clog2(UC_DEPTH);

  typedef logic [UC_AW-1:0] uc_addr_t;

  typedef enum logic [1:0] {
    OP_CLAIM = 2'd0,
    OP_ROUND = 2'd1,
    OP_FINAL = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ROUND = 2'd1,
    ST_FINAL = 2'd2
  } status_t;

  // adder operand A
  typedef enum logic [1:0] {
    AA_A   = 2'd0,
    AA_ACC = 2'd1,
    AA_T   = 2'd2,
    AA_C1  = 2'd3
  } add_a_t;

  // adder operand B
  typedef enum logic [2:0] {
    AB_ZERO = 3'd0,
    AB_A    = 3'd1,
    AB_C2   = 3'd2,
    AB_T    = 3'd3,
    AB_M    = 3'd4
  } add_b_t;

  // adder destination
  typedef enum logic [1:0] {
    DST_NONE = 2'd0,
    DST_ACC  = 2'd1,
    DST_T    = 2'd2,
    DST_EXP  = 2'd3
  } dst_t;

  // multiplier operand, always times the challenge
  typedef enum logic [1:0] {
    MA_C1 = 2'd0,
    MA_C2 = 2'd1,
    MA_M  = 2'd2
  } mul_a_t;

  // value compared against the expected sum
  typedef enum logic {
    CMP_ACC = 1'b0,
    CMP_A   = 1'b1
  } cmp_t;

  typedef struct packed {
    add_a_t   add_a;
    add_b_t   add_b;
    dst_t     dst;
    logic     mul_en;
    mul_a_t   mul_a;
    logic     m_en;
    cmp_t     cmp_sel;
    logic     jne;
    uc_addr_t target;
    logic     done;
    status_t  status;
  } ctrl_t;

  localparam uc_addr_t UA_CLAIM  = UC_AW'(0);
  localparam uc_addr_t UA_ROUND  = UC_AW'(1);
  localparam uc_addr_t UA_RFAIL  = UC_AW'(8);
  localparam uc_addr_t UA_FINAL  = UC_AW'(9);
  localparam uc_addr_t UA_FFAIL  = UC_AW'(10);
  localparam uc_addr_t UA_NOP    = UC_AW'(11);

  function automatic uc_addr_t uc_entry(input opcode_t op);
    uc_addr_t a;
    case (op)
      OP_CLAIM: a = UA_CLAIM;
      OP_ROUND: a = UA_ROUND;
      OP_FINAL: a = UA_FINAL;
      default:  a = UA_NOP;
    endcase
    return a;
  endfunction

  localparam ctrl_t UC_IDLE = '{
    add_a: AA_A, add_b: AB_ZERO, dst: DST_NONE, mul_en: 1'b0, mul_a: MA_C1,
    m_en: 1'b0, cmp_sel: CMP_ACC, jne: 1'b0, target: UA_CLAIM, done: 1'b0,
    status: ST_OK
  };

  // Control program. The multiplier product is registered in prod_r at its issue
  // step; the step after that reduces it and loads the result into m.
  function automatic ctrl_t uc_word(input uc_addr_t a);
    ctrl_t w;
    w = UC_IDLE;
    case (a)
      // claim: expected = a
      UC_AW'(0): begin
        w.dst  = DST_EXP;
        w.done = 1'b1;
      end
      // round: prod = c1*r, acc = 2a
      UC_AW'(1): begin
        w.mul_en = 1'b1;
        w.mul_a  = MA_C1;
        w.add_b  = AB_A;
        w.dst    = DST_ACC;
      end
      // m = c1*r mod p, t = c1 + c2
      UC_AW'(2): begin
        w.m_en  = 1'b1;
        w.add_a = AA_C1;
        w.add_b = AB_C2;
        w.dst   = DST_T;
      end
      // prod = c2*r, acc = 2a + c1 + c2
      UC_AW'(3): begin
        w.mul_en = 1'b1;
        w.mul_a  = MA_C2;
        w.add_a  = AA_ACC;
        w.add_b  = AB_T;
        w.dst    = DST_ACC;
      end
      // check sum, t = a + c1*r, m = c2*r mod p
      UC_AW'(4): begin
        w.cmp_sel = CMP_ACC;
        w.jne     = 1'b1;
        w.target  = UA_RFAIL;
        w.m_en    = 1'b1;
        w.add_b   = AB_M;
        w.dst     = DST_T;
      end
      // prod = c2*r*r
      UC_AW'(5): begin
        w.mul_en = 1'b1;
        w.mul_a  = MA_M;
      end
      UC_AW'(6): begin
        w.m_en = 1'b1;
      end
      // expected = a + c1*r + c2*r^2
      UC_AW'(7): begin
        w.add_a = AA_T;
        w.add_b = AB_M;
        w.dst   = DST_EXP;
        w.done  = 1'b1;
      end
      UC_AW'(8): begin
        w.done   = 1'b1;
        w.status = ST_ROUND;
      end
      // final: compare a with expected
      UC_AW'(9): begin
        w.cmp_sel = CMP_A;
        w.jne     = 1'b1;
        w.target  = UA_FFAIL;
        w.done    = 1'b1;
      end
      UC_AW'(10): begin
        w.done   = 1'b1;
        w.status = ST_FINAL;
      end
      UC_AW'(11): begin
        w.done = 1'b1;
      end
      default: w = UC_IDLE;
    endcase
    return w;
  endfunction

endpackage

>>> design/svr_sequencer.sv
// Step counter and control-word fetch for the sumcheck round verifier.
`timescale 1ns / 1ps

module svr_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  svr_pkg::opcode_t    opcode,
  input  logic                ne,
  output svr_pkg::ctrl_t      ctrl,
  output logic                busy,
  output logic                fin
);

  svr_pkg::uc_addr_t pc_r, pc_nxt;
  logic              busy_r, busy_nxt;
  svr_pkg::ctrl_t    word;
  logic              take_jump;

  always_comb begin
    word      = svr_pkg::uc_word(pc_r);
    take_jump = busy_r & word.jne & ne;
    fin       = busy_r & word.done & ~take_jump;
    ctrl      = busy_r ? word : svr_pkg::UC_IDLE;
  end

  // next step
  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (start) begin
      pc_nxt   = svr_pkg::uc_entry(opcode);
      busy_nxt = 1'b1;
    end else if (take_jump) begin
      pc_nxt = word.target;
    end else if (fin) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      pc_nxt = pc_r + svr_pkg::UC_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= svr_pkg::UA_CLAIM;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

>>> design/svr_datapath.sv
// Operand registers, modular adder, shared multiplier and reduction of the verifier.
`timescale 1ns / 1ps

module svr_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic [30:0]      value_a,
  input  logic [30:0]      coeff_one,
  input  logic [30:0]      coeff_two,
  input  logic [30:0]      challenge,
  input  svr_pkg::ctrl_t   ctrl,
  input  logic             fin,
  output logic             ne,
  output logic [1:0]       status,
  output logic [30:0]      expected_out
);

  logic [30:0] a_r, c1_r, c2_r, r_r;
  logic [30:0] acc_r, t_r, m_r, exp_r, exp_nxt;
  logic [61:0] prod_r;
  logic [1:0]  status_r;
  logic [30:0] out_exp_r;

  logic [30:0] opa, opb, sum, mul_x, red, cmp_v;
  logic [31:0] raw, fold;

  function automatic logic [30:0] canon(input logic [30:0] x);
    return (x == svr_pkg::FIELD_P) ? 31'd0 : x;
  endfunction

  always_comb begin
    case (ctrl.add_a)
      svr_pkg::AA_A:   opa = a_r;
      svr_pkg::AA_ACC: opa = acc_r;
      svr_pkg::AA_T:   opa = t_r;
      svr_pkg::AA_C1:  opa = c1_r;
      default:         opa = a_r;
    endcase
    case (ctrl.add_b)
      svr_pkg::AB_ZERO: opb = 31'd0;
      svr_pkg::AB_A:    opb = a_r;
      svr_pkg::AB_C2:   opb = c2_r;
      svr_pkg::AB_T:    opb = t_r;
      svr_pkg::AB_M:    opb = m_r;
      default:          opb = 31'd0;
    endcase
    raw = {1'b0, opa} + {1'b0, opb};
    sum = (raw >= {1'b0, svr_pkg::FIELD_P}) ? 31'(raw - {1'b0, svr_pkg::FIELD_P})
                                            : raw[30:0];
  end

  always_comb begin
    case (ctrl.mul_a)
      svr_pkg::MA_C1: mul_x = c1_r;
      svr_pkg::MA_C2: mul_x = c2_r;
      svr_pkg::MA_M:  mul_x = m_r;
      default:        mul_x = c1_r;
    endcase
    // fold high half onto low half: 2^31 = 1 mod p
    fold = {1'b0, prod_r[61:31]} + {1'b0, prod_r[30:0]};
    red  = (fold >= {1'b0, svr_pkg::FIELD_P}) ? 31'(fold - {1'b0, svr_pkg::FIELD_P})
                                              : fold[30:0];
  end

  always_comb begin
    cmp_v   = (ctrl.cmp_sel == svr_pkg::CMP_A) ? a_r : acc_r;
    ne      = (cmp_v != exp_r);
    exp_nxt = (ctrl.dst == svr_pkg::DST_EXP) ? sum : exp_r;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_r  <= canon(value_a);
      c1_r <= canon(coeff_one);
      c2_r <= canon(coeff_two);
      r_r  <= canon(challenge);
    end
    if (ctrl.dst == svr_pkg::DST_ACC) acc_r <= sum;
    if (ctrl.dst == svr_pkg::DST_T)   t_r   <= sum;
    if (ctrl.mul_en) prod_r <= 62'(mul_x) * 62'(r_r);
    if (ctrl.m_en)   m_r    <= red;
    if (fin) begin
      status_r  <= ctrl.status;
      out_exp_r <= exp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= 31'd0;
    end else begin
      exp_r <= exp_nxt;
    end
  end

  assign status       = status_r;
  assign expected_out = out_exp_r;

endmodule

>>> design/sumcheck_verifier_round.sv
// Each opcode starts its own control program on input transfer; out_valid rises
// when that program finishes, and a round that fails its check jumps to its fail step.
// The single control program and the shared 31x31 multiplier serve one item at a
// time: no new item is taken while the sequencer is busy.
// Reset (rst_n low, synchronous): sequencer idle, no result pending, expected sum 0.
`timescale 1ns / 1ps

module sumcheck_verifier_round (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [30:0] in_value_a,
  input  logic [30:0] in_coeff_one,
  input  logic [30:0] in_coeff_two,
  input  logic [30:0] in_challenge,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [30:0] out_expected_out
);

  svr_pkg::ctrl_t ctrl;
  logic           busy, fin, ne, start;
  logic           out_valid_r, out_valid_nxt;

  // Take a new item once the program is idle and the result slot is free or
  // emptying in this cycle.
  assign in_stall = busy | (out_valid_r & out_stall);
  assign start    = in_valid & ~in_stall;

  svr_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (svr_pkg::opcode_t'(in_opcode)),
    .ne     (ne),
    .ctrl   (ctrl),
    .busy   (busy),
    .fin    (fin)
  );

  svr_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (start),
    .value_a      (in_value_a),
    .coeff_one    (in_coeff_one),
    .coeff_two    (in_coeff_two),
    .challenge    (in_challenge),
    .ctrl         (ctrl),
    .fin          (fin),
    .ne           (ne),
    .status       (out_status),
    .expected_out (out_expected_out)
  );

  // Raise valid when the program finishes; drop it after the transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> test/sumcheck_verifier_round_tb.sv
// Self-checking testbench for the sumcheck round verifier, with its own field predictor.
`timescale 1ns / 1ps

module sumcheck_verifier_round_tb;

  // Watchdog limit for the whole run, well above what a correct run needs.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // Drain margin past the longest program, the passing round.
  localparam int          DRAIN_CYCLES = 12;
  // 2^30 is the inverse of 2 mod p, since 2^31 = p + 1.
  localparam logic [30:0] INV_TWO      = 31'h4000_0000;

  typedef struct packed {
    svr_pkg::status_t status;
    logic [30:0]      sum;
  } verdict_t;

  // Running-sum predictor plus the queue of verdicts still owed by the block.
  class round_scoreboard;
    logic [30:0] running_sum;
    verdict_t    verdicts[$];
    int          errors;

    function new();
      running_sum = '0;
      errors      = 0;
    endfunction

    static function logic [30:0] add_mod(input logic [30:0] x, y);
      logic [63:0] s;
      s = 64'(x) + 64'(y);
      return 31'(s % 64'(svr_pkg::FIELD_P));
    endfunction

    static function logic [30:0] mul_mod(input logic [30:0] x, y);
      logic [63:0] prod;
      prod = 64'(x) * 64'(y);
      return 31'(prod % 64'(svr_pkg::FIELD_P));
    endfunction

    // y must be canonical
    static function logic [30:0] sub_mod(input logic [30:0] x, y);
      return add_mod(x, svr_pkg::FIELD_P - y);
    endfunction

    function void note_input(input svr_pkg::opcode_t op,
                             input logic [30:0] a_raw, c1_raw, c2_raw, r_raw);
      logic [30:0] a, c1, c2, r, tot;
      verdict_t    v;
      // A value equal to p stands for zero.
      a  = add_mod(a_raw, 31'd0);
      c1 = add_mod(c1_raw, 31'd0);
      c2 = add_mod(c2_raw, 31'd0);
      r  = add_mod(r_raw, 31'd0);
      v.status = svr_pkg::ST_OK;
      case (op)
        svr_pkg::OP_CLAIM: running_sum = a;
        svr_pkg::OP_ROUND: begin
          tot = add_mod(add_mod(a, a), add_mod(c1, c2));
          if (tot != running_sum) begin
            v.status = svr_pkg::ST_ROUND;
          end else begin
            running_sum = add_mod(add_mod(a, mul_mod(c1, r)), mul_mod(mul_mod(c2, r), r));
          end
        end
        svr_pkg::OP_FINAL: begin
          if (a != running_sum) v.status = svr_pkg::ST_FINAL;
        end
        default: ;
      endcase
      v.sum = running_sum;
      verdicts.insert(verdicts.size(), v);
    endfunction

    function void check_result(input logic [1:0] status, input logic [30:0] sum);
      verdict_t want;
      if (verdicts.size() == 0) begin
        $error("unexpected result: status %0d, expected_out %0d", status, sum);
        errors++;
        return;
      end
      want = verdicts.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (sum !== want.sum) begin
        $error("expected_out: expected %0d, got %0d", want.sum, sum);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic [1:0]  in_opcode    = '0;
  logic [30:0] in_value_a   = '0;
  logic [30:0] in_coeff_one = '0;
  logic [30:0] in_coeff_two = '0;
  logic [30:0] in_challenge = '0;
  logic        out_stall    = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [30:0] out_expected_out;

  round_scoreboard sb;
  int unsigned     cycle_cnt     = 0;
  int              send_idle_pct = 0;
  int              stall_pct     = 0;
  int              hold_req      = 0;
  int              hold_left     = 0;

  sumcheck_verifier_round dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_value_a       (in_value_a),
    .in_coeff_one     (in_coeff_one),
    .in_coeff_two     (in_coeff_two),
    .in_challenge     (in_challenge),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_expected_out (out_expected_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Bail out if the block hangs somewhere.
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: a long hold-off request takes priority over the random stall rate.
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_status, out_expected_out);
  end

  // Field value biased toward the edges; p itself shows up as a non-canonical zero.
  function automatic logic [30:0] pick_field();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 15))
      0:       return 31'd0;
      1:       return 31'd1;
      2:       return svr_pkg::FIELD_P - 31'd1;
      3:       return svr_pkg::FIELD_P;
      default: return w[30:0];
    endcase
  endfunction

  // Present one transfer at the falling edge, hold it until accepted, then predict.
  task automatic send_item(input svr_pkg::opcode_t op, input logic [30:0] a, c1, c2, r);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_value_a   <= a;
    in_coeff_one <= c1;
    in_coeff_two <= c2;
    in_challenge <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(op, a, c1, c2, r);
  endtask

  // Solve c0 from 2*c0 + c1 + c2 = running sum so the round passes; spoil it to fail.
  task automatic send_round(input logic [30:0] c1, c2, r, input bit spoil);
    logic [30:0] c0;
    c0 = round_scoreboard::mul_mod(
           round_scoreboard::sub_mod(sb.running_sum, round_scoreboard::add_mod(c1, c2)),
           INV_TWO);
    if (spoil) begin
      c0 = round_scoreboard::add_mod(c0, 31'd1);
    end else if (c0 == 31'd0 && $urandom_range(0, 1) == 1) begin
      c0 = svr_pkg::FIELD_P;
    end
    send_item(svr_pkg::OP_ROUND, c0, c1, c2, r);
  endtask

  task automatic send_final(input bit honest);
    logic [30:0] a;
    a = honest ? sb.running_sum : pick_field();
    if (honest && a == 31'd0 && $urandom_range(0, 1) == 1) a = svr_pkg::FIELD_P;
    send_item(svr_pkg::OP_FINAL, a, pick_field(), pick_field(), pick_field());
  endtask

  // Drop valid and wait out every owed result plus the block's tail.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    // final against the reset sum: match, then mismatch
    send_item(svr_pkg::OP_FINAL, 31'd0, svr_pkg::FIELD_P, svr_pkg::FIELD_P, svr_pkg::FIELD_P);
    send_item(svr_pkg::OP_FINAL, 31'd5, 31'd0, 31'd0, 31'd0);
    // all-zero round passes against the reset sum
    send_item(svr_pkg::OP_ROUND, 31'd0, 31'd0, 31'd0, '1);
    send_item(svr_pkg::OP_NOP, '1, '1, '1, '1);
    send_item(svr_pkg::OP_CLAIM, svr_pkg::FIELD_P - 31'd1, '1, '1, '1);
    send_round(svr_pkg::FIELD_P - 31'd1, svr_pkg::FIELD_P - 31'd1,
               svr_pkg::FIELD_P - 31'd1, 1'b0);
    // failing round: challenge must be ignored
    send_round(31'h2AAA_AAAA, 31'h5555_5555, '1, 1'b1);
    send_final(1'b1);
    // non-canonical claim loads zero
    send_item(svr_pkg::OP_CLAIM, svr_pkg::FIELD_P, 31'd0, 31'd0, 31'd0);
    send_item(svr_pkg::OP_ROUND, svr_pkg::FIELD_P, svr_pkg::FIELD_P, svr_pkg::FIELD_P,
              svr_pkg::FIELD_P);
    send_item(svr_pkg::OP_FINAL, svr_pkg::FIELD_P, 31'd0, 31'd0, 31'd0);
    send_item(svr_pkg::OP_CLAIM, 31'h5555_5555, 31'h2AAA_AAAA, 31'h2AAA_AAAA,
              31'h2AAA_AAAA);
    send_round(31'd0, 31'd0, svr_pkg::FIELD_P - 31'd1, 1'b0);
    send_round(svr_pkg::FIELD_P, 31'd1, 31'd0, 1'b0);
    send_round(31'd1, svr_pkg::FIELD_P - 31'd1, 31'd1, 1'b0);
    send_round(svr_pkg::FIELD_P - 31'd1, 31'd0, svr_pkg::FIELD_P, 1'b0);
    send_round(31'h2AAA_AAAA, 31'h5555_5555, 31'h5555_5555, 1'b0);
    send_round(31'd7, 31'd9, 31'd3, 1'b1);
    send_final(1'b1);
    send_item(svr_pkg::OP_FINAL, 31'h7FFF_FFFE, 31'd0, 31'd0, 31'd0);
    send_item(svr_pkg::OP_NOP, 31'd0, 31'd0, 31'd0, 31'd0);
    send_item(svr_pkg::OP_CLAIM, 31'd0, '1, '1, '1);
    send_final(1'b0);
  endtask

  // Mostly full protocol runs (claim, rounds, final) with random content; the rest noise.
  task automatic run_random(input int count);
    int sent;
    int rounds;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 8) begin
        send_item(svr_pkg::OP_CLAIM, pick_field(), pick_field(), pick_field(), pick_field());
        rounds = $urandom_range(1, 6);
        for (int i = 0; i < rounds; i++) begin
          send_round(pick_field(), pick_field(), pick_field(), $urandom_range(0, 9) == 0);
        end
        send_final($urandom_range(0, 3) != 0);
        sent += rounds + 2;
      end else begin
        send_item(svr_pkg::opcode_t'($urandom_range(0, 3)), pick_field(), pick_field(),
                  pick_field(), pick_field());
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    drain();

    // Hold the result side off for a long stretch while items keep coming,
    // so the block fills and pushes back on its input.
    hold_req = 300;
    run_random(40);
    drain();

    // Idle phases: none, sender idle, receiver stalling, light on both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 60;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 60;
        end
        default: begin
          send_idle_pct = 9;
          stall_pct     = 9;
        end
      endcase
      run_random(350);
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/svr_pkg.sv
design/svr_sequencer.sv
design/svr_datapath.sv
design/sumcheck_verifier_round.sv
test/sumcheck_verifier_round_tb.sv
